>>> rtl/core/lswt_pkg.sv
// ----------------------------------------------------------------------------
// lswt_pkg
// Shared types, codes and helpers of the locality score warp throttle.
// ----------------------------------------------------------------------------
`default_nettype none

package lswt_pkg;

    localparam int WARP_CNT_DEF = 48;
    localparam int PCT_SCALE    = 100;

    // register indexes
    localparam logic [2:0] REG_VICTIM = 3'd0;
    localparam logic [2:0] REG_OWN    = 3'd1;
    localparam logic [2:0] REG_OTHER  = 3'd2;
    localparam logic [2:0] REG_MISS   = 3'd3;
    localparam logic [2:0] REG_TICK   = 3'd4;
    localparam logic [2:0] REG_BASE   = 3'd5;
    localparam logic [2:0] REG_CAP    = 3'd6;
    localparam logic [2:0] REG_CUTOFF = 3'd7;

    // actions
    localparam logic [1:0] ACT_VICTIM = 2'd0;
    localparam logic [1:0] ACT_ACCESS = 2'd1;
    localparam logic [1:0] ACT_TICK   = 2'd2;
    localparam logic [1:0] ACT_EXIT   = 2'd3;

    // access status
    localparam logic [1:0] ST_HIT  = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;

    typedef struct packed {
        logic [1:0]  action;
        logic [5:0]  warp_index;
        logic [1:0]  access_status;
        logic        own_line;
        logic [47:0] active_mask;
    } t_in_item;

    typedef struct packed {
        logic [47:0]        exclusive_mask;
        logic               throttling;
        logic signed [31:0] warp_score;
        logic [30:0]        cutoff_now;
        logic signed [31:0] summed_score;
        logic [5:0]         active_count;
    } t_out_item;

    typedef struct packed {
        logic [2:0]  index;
        logic [31:0] value;
    } t_cfg_req;

    typedef struct packed {
        logic       ld_item;
        logic       div_init;
        logic       div_step;
        logic       div_done;
        logic       rd;
        logic       use_w;
        logic       scan;
        logic [5:0] idx;
        logic       add_sum;
        logic       clamp;
        logic       tick;
        logic       exit_wr;
        logic       tick_start;
        logic       sel_start;
        logic       sel_pick;
        logic       tick_end;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic dirty;
        logic w_ok;
        logic is_tick;
        logic is_exit;
        logic pts_op;
        logic pick_done;
    } t_sts;

    function automatic logic signed [31:0] f_sat32(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31]) begin
            r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [30:0] f_max1(input logic [21:0] p);
        return (p == 22'd0) ? 31'd1 : 31'(p);
    endfunction

    function automatic logic [30:0] f_static_cut(input logic [31:0] cset,
                                                 input logic [14:0] base,
                                                 input logic [6:0]  nw);
        logic [30:0] r;
        if (!cset[31] && (cset != 32'd0)) begin
            r = cset[30:0];
        end else begin
            r = f_max1(22'(nw) * 22'(base));
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/lswt_chan_if.sv
// ----------------------------------------------------------------------------
// lswt_chan_if
// Valid/ready channel carrying one payload type.
// ----------------------------------------------------------------------------
`default_nettype none

interface lswt_chan_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/lswt_ram.sv
// ----------------------------------------------------------------------------
// lswt_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lswt_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_wa,
    input  wire logic [Width-1:0]         i_wd,
    input  wire logic                     i_re,
    input  wire logic [$clog2(Depth)-1:0] i_ra,
    output logic      [Width-1:0]         o_rd
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        if (i_re) begin
            o_rd <= r_mem[i_ra];
        end
    end
endmodule

`default_nettype wire

>>> rtl/core/lswt_datapath.sv
// ----------------------------------------------------------------------------
// lswt_datapath
// Score table, point arithmetic, ranking compare and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lswt_datapath import lswt_pkg::*; #(
    parameter int NumWarps = WARP_CNT_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_in_item  i_item,
    input  wire logic      i_cfg_we,
    input  wire t_cfg_req  i_cfg,
    input  wire t_cmd      i_cmd,
    output t_sts           o_sts,
    output t_out_item      o_res
);
    localparam int AW = (NumWarps > 1) ? $clog2(NumWarps) : 1;
    localparam int VD = 1 << AW;

    // reciprocals: x/25 as (x*REC25)>>34 for x < 2^29, x/100 as (x*REC100)>>24 for x < 2^17
    localparam logic [29:0] REC25  = 30'd687194768;
    localparam logic [17:0] REC100 = 18'd167773;

    // configuration
    logic [14:0]        r_vhp;
    logic signed [15:0] r_own, r_oth, r_miss, r_tick;
    logic [14:0]        r_base;
    logic [9:0]         r_cap;
    logic [31:0]        r_cset;
    logic [30:0]        r_cut;
    logic               r_dirty;

    // cap value and cap threshold
    logic [30:0] r_capval;
    logic [41:0] r_thr;
    logic [24:0] r_cq;
    logic [34:0] r_hi;
    logic [16:0] r_lo;

    // current request
    logic [1:0]    r_act;
    logic [5:0]    r_w;
    logic [1:0]    r_st;
    logic          r_ownl;
    logic [VD-1:0] r_mask;

    // table access
    logic [VD-1:0]      r_valid;
    logic [AW-1:0]      r_addr;
    logic               r_pv;
    logic signed [31:0] r_s;
    logic               r_gt;

    // tick state
    logic [VD-1:0]      r_excl, r_taken;
    logic               r_lim, r_limw;
    logic signed [31:0] r_sum;
    logic [6:0]         r_cnt, r_tcnt;
    logic signed [38:0] r_acc;
    logic               r_hb;
    logic signed [31:0] r_bv;
    logic [AW-1:0]      r_bi;
    t_out_item          r_out;

    logic [31:0]        ram_q;
    logic signed [31:0] score_rd, base_s, n_score;
    logic signed [15:0] pts;
    logic [37:0]        s100;
    logic               we, capt;
    logic [AW-1:0]      wa, ra;
    logic [31:0]        wd;
    logic [58:0]        qc_prod;
    logic [6:0]         cut_rem;
    logic [34:0]        lo_prod;
    logic [35:0]        cap_sum;
    logic signed [38:0] acc_nx;
    logic               reach;
    logic [63:0]        excl64, mask64;

    lswt_ram #(.Width(32), .Depth(VD)) u_ram (
        .i_clk (i_clk),
        .i_we  (we),
        .i_wa  (wa),
        .i_wd  (wd),
        .i_re  (i_cmd.rd),
        .i_ra  (ra),
        .o_rd  (ram_q)
    );

    always_comb begin
        base_s   = $signed({17'd0, r_base});
        score_rd = r_valid[r_addr] ? $signed(ram_q) : base_s;
        if (i_cmd.tick) begin
            pts = r_tick;
        end else if (r_act == ACT_VICTIM) begin
            pts = $signed({1'b0, r_vhp});
        end else if (r_st == ST_HIT) begin
            pts = r_ownl ? r_own : r_oth;
        end else begin
            pts = r_miss;
        end
        s100    = 38'(r_s[30:0]) * 38'(PCT_SCALE);
        capt    = (r_cap != 10'd0) && (42'(s100) >= r_thr);
        if (r_s <= base_s) begin
            n_score = base_s;
        end else if (capt) begin
            n_score = $signed({1'b0, r_capval});
        end else begin
            n_score = r_s;
        end
        we      = (i_cmd.clamp && (!i_cmd.tick || r_gt)) || i_cmd.exit_wr;
        wa      = i_cmd.exit_wr ? r_w[AW-1:0] : r_addr;
        wd      = i_cmd.exit_wr ? 32'd0 : n_score;
        ra      = i_cmd.use_w ? r_w[AW-1:0] : i_cmd.idx[AW-1:0];
        // cap*cut/100 = cap*(cut/100) + cap*(cut%100)/100
        qc_prod = 59'(r_cut[30:2]) * 59'(REC25);
        cut_rem = 7'(r_cut - 31'(r_cq) * 31'(PCT_SCALE));
        lo_prod = 35'(r_lo) * 35'(REC100);
        cap_sum = 36'(r_hi) + 36'(lo_prod[34:24]);
        acc_nx  = r_acc + 39'(r_bv);
        reach   = acc_nx >= $signed({8'd0, r_cut});
        excl64  = 64'(r_excl);
        mask64  = 64'(i_item.active_mask);
    end

    always_comb begin
        o_sts.dirty     = r_dirty;
        o_sts.w_ok      = {1'b0, r_w} < 7'(NumWarps);
        o_sts.is_tick   = (r_act == ACT_TICK);
        o_sts.is_exit   = (r_act == ACT_EXIT);
        o_sts.pts_op    = (r_act == ACT_VICTIM) ||
                          ((r_act == ACT_ACCESS) && ((r_st == ST_HIT) || (r_st == ST_MISS)));
        o_sts.pick_done = !r_hb || reach;
        o_res           = r_out;
    end

    // control and configuration state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vhp   <= '0;
            r_own   <= '0;
            r_oth   <= '0;
            r_miss  <= '0;
            r_tick  <= '0;
            r_base  <= '0;
            r_cap   <= '0;
            r_cset  <= '0;
            r_cut   <= 31'd1;
            r_dirty <= 1'b1;
            r_valid <= '0;
            r_excl  <= '0;
            r_lim   <= 1'b0;
            r_sum   <= '0;
            r_cnt   <= '0;
            r_pv    <= 1'b0;
        end else begin
            r_pv <= i_cmd.rd && i_cmd.scan;
            // a base, cap or cutoff write during the recompute sets it again and forces another pass
            if (i_cmd.div_init) begin
                r_dirty <= 1'b0;
            end
            if (we) begin
                r_valid[wa] <= 1'b1;
            end
            if (i_cmd.exit_wr && (r_sum >= $signed({1'b0, r_cut}))) begin
                r_excl[r_w[AW-1:0]] <= 1'b0;
            end
            if (i_cmd.sel_start) begin
                r_excl <= '0;
            end
            if (i_cmd.sel_pick && r_hb) begin
                r_excl[r_bi] <= 1'b1;
            end
            if (i_cmd.tick_end) begin
                r_sum   <= (r_acc > 39'sh0_7fff_ffff) ? 32'sh7fff_ffff : r_acc[31:0];
                r_lim   <= r_limw;
                r_cnt   <= r_tcnt;
                r_dirty <= 1'b1;
                if (r_cset[31]) begin
                    r_cut <= f_max1(22'(r_tcnt) * 22'(r_base));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg.index)
                    REG_VICTIM: r_vhp  <= i_cfg.value[14:0];
                    REG_OWN:    r_own  <= i_cfg.value[15:0];
                    REG_OTHER:  r_oth  <= i_cfg.value[15:0];
                    REG_MISS:   r_miss <= i_cfg.value[15:0];
                    REG_TICK:   r_tick <= i_cfg.value[15:0];
                    REG_BASE: begin
                        r_base  <= i_cfg.value[14:0];
                        r_valid <= '0;
                        r_cut   <= f_static_cut(r_cset, i_cfg.value[14:0], 7'(NumWarps));
                        r_dirty <= 1'b1;
                    end
                    REG_CAP: begin
                        r_cap   <= i_cfg.value[9:0];
                        r_dirty <= 1'b1;
                    end
                    REG_CUTOFF: begin
                        r_cset  <= i_cfg.value;
                        r_cut   <= f_static_cut(i_cfg.value, r_base, 7'(NumWarps));
                        r_dirty <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_item) begin
            r_act  <= i_item.action;
            r_w    <= i_item.warp_index;
            r_st   <= i_item.access_status;
            r_ownl <= i_item.own_line;
            r_mask <= VD'(mask64[NumWarps-1:0]);
        end
        if (i_cmd.rd) begin
            r_addr <= ra;
        end
        if (i_cmd.div_init) begin
            r_cq  <= qc_prod[58:34];
            r_thr <= 42'({1'b0, r_cap} + 11'd1) * 42'(r_cut);
        end
        if (i_cmd.div_step) begin
            r_hi <= 35'(r_cap) * 35'(r_cq);
            r_lo <= 17'(r_cap) * 17'(cut_rem);
        end
        if (i_cmd.div_done) begin
            r_capval <= (|cap_sum[35:31]) ? '1 : cap_sum[30:0];
        end
        if (i_cmd.add_sum) begin
            r_s  <= f_sat32(33'(score_rd) + 33'(pts));
            r_gt <= score_rd > base_s;
        end
        if (i_cmd.tick_start) begin
            r_tcnt <= '0;
        end
        if (i_cmd.clamp && i_cmd.tick) begin
            r_tcnt <= r_tcnt + 7'(r_mask[r_addr]);
        end
        if (i_cmd.sel_start) begin
            r_taken <= '0;
            r_acc   <= '0;
            r_hb    <= 1'b0;
            r_limw  <= 1'b0;
        end else if (i_cmd.sel_pick) begin
            r_hb <= 1'b0;
            if (r_hb) begin
                r_taken[r_bi] <= 1'b1;
                r_acc         <= acc_nx;
                r_limw        <= reach;
            end
        end else if (r_pv && r_mask[r_addr] && !r_taken[r_addr] &&
                     (!r_hb || (score_rd > r_bv))) begin
            r_hb <= 1'b1;
            r_bv <= score_rd;
            r_bi <= r_addr;
        end
        if (i_cmd.out_load) begin
            r_out.exclusive_mask <= excl64[47:0];
            r_out.throttling     <= r_lim;
            r_out.warp_score     <= o_sts.w_ok ? score_rd : 32'sd0;
            r_out.cutoff_now     <= r_cut;
            r_out.summed_score   <= r_sum;
            r_out.active_count   <= r_cnt[5:0];
        end
    end
endmodule

`default_nettype wire

>>> rtl/core/lswt_ctrl.sv
// ----------------------------------------------------------------------------
// lswt_ctrl
// Sequencer for request handling, tick passes and cap recompute.
// ----------------------------------------------------------------------------
`default_nettype none

module lswt_ctrl import lswt_pkg::*; #(
    parameter int NumWarps = WARP_CNT_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DMUL   = 5'd1;
    localparam logic [4:0] S_DSTEP  = 5'd2;
    localparam logic [4:0] S_DFIN   = 5'd3;
    localparam logic [4:0] S_DISP   = 5'd4;
    localparam logic [4:0] S_ARD    = 5'd5;
    localparam logic [4:0] S_ASUM   = 5'd6;
    localparam logic [4:0] S_ACLP   = 5'd7;
    localparam logic [4:0] S_EXIT   = 5'd8;
    localparam logic [4:0] S_TINIT  = 5'd9;
    localparam logic [4:0] S_TRD    = 5'd10;
    localparam logic [4:0] S_TSUM   = 5'd11;
    localparam logic [4:0] S_TCLP   = 5'd12;
    localparam logic [4:0] S_SINIT  = 5'd13;
    localparam logic [4:0] S_SSCAN  = 5'd14;
    localparam logic [4:0] S_SDRAIN = 5'd15;
    localparam logic [4:0] S_SPICK  = 5'd16;
    localparam logic [4:0] S_TEND   = 5'd17;
    localparam logic [4:0] S_RRD    = 5'd18;
    localparam logic [4:0] S_ROUT   = 5'd19;

    logic [4:0] r_state, n_state;
    logic [6:0] r_idx, n_idx;
    logic       r_ovld, n_ovld;
    logic       last;

    assign last        = (r_idx == 7'(NumWarps - 1));
    assign o_in_ready  = (r_state == S_IDLE) && !i_sts.dirty;
    assign o_out_valid = r_ovld;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_ovld  = r_ovld && !i_out_ready;
        o_cmd   = '0;
        o_cmd.idx = r_idx[5:0];
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.ld_item = 1'b1;
                    n_state       = S_DISP;
                end else if (i_sts.dirty) begin
                    n_state = S_DMUL;
                end
            end
            S_DMUL: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DSTEP;
            end
            S_DSTEP: begin
                o_cmd.div_step = 1'b1;
                n_state        = S_DFIN;
            end
            S_DFIN: begin
                o_cmd.div_done = 1'b1;
                n_state        = S_IDLE;
            end
            S_DISP: begin
                if (i_sts.is_tick) begin
                    n_state = S_TINIT;
                end else if (i_sts.w_ok && i_sts.is_exit) begin
                    n_state = S_EXIT;
                end else if (i_sts.w_ok && i_sts.pts_op) begin
                    n_state = S_ARD;
                end else begin
                    n_state = S_RRD;
                end
            end
            S_ARD: begin
                o_cmd.rd    = 1'b1;
                o_cmd.use_w = 1'b1;
                n_state     = S_ASUM;
            end
            S_ASUM: begin
                o_cmd.add_sum = 1'b1;
                n_state       = S_ACLP;
            end
            S_ACLP: begin
                o_cmd.clamp = 1'b1;
                n_state     = S_RRD;
            end
            S_EXIT: begin
                o_cmd.exit_wr = 1'b1;
                n_state       = S_RRD;
            end
            S_TINIT: begin
                o_cmd.tick_start = 1'b1;
                n_idx            = '0;
                n_state          = S_TRD;
            end
            S_TRD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_TSUM;
            end
            S_TSUM: begin
                o_cmd.add_sum = 1'b1;
                o_cmd.tick    = 1'b1;
                n_state       = S_TCLP;
            end
            S_TCLP: begin
                o_cmd.clamp = 1'b1;
                o_cmd.tick  = 1'b1;
                if (last) begin
                    n_state = S_SINIT;
                end else begin
                    n_idx   = r_idx + 7'd1;
                    n_state = S_TRD;
                end
            end
            S_SINIT: begin
                o_cmd.sel_start = 1'b1;
                n_idx           = '0;
                n_state         = S_SSCAN;
            end
            S_SSCAN: begin
                o_cmd.rd   = 1'b1;
                o_cmd.scan = 1'b1;
                if (last) begin
                    n_state = S_SDRAIN;
                end else begin
                    n_idx = r_idx + 7'd1;
                end
            end
            S_SDRAIN: begin
                n_state = S_SPICK;
            end
            S_SPICK: begin
                o_cmd.sel_pick = 1'b1;
                n_idx          = '0;
                n_state        = i_sts.pick_done ? S_TEND : S_SSCAN;
            end
            S_TEND: begin
                o_cmd.tick_end = 1'b1;
                n_state        = S_RRD;
            end
            S_RRD: begin
                o_cmd.rd    = 1'b1;
                o_cmd.use_w = 1'b1;
                n_state     = S_ROUT;
            end
            S_ROUT: begin
                if (!r_ovld || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_ovld         = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_ovld  <= n_ovld;
        end
    end
endmodule

`default_nettype wire

>>> rtl/core/locality_score_warp_throttle_top.sv
// request: victim hit or access adds points to the score and clamps it, exit zeroes it
// tick: tick points added to each warp's score that is above base, then scan rounds, one round per selected
//   warp and one more when the cutoff is not reached, all through the one table port
// after a tick or a base/cap/cutoff write, the cap is recomputed before the next request
// one request in flight; the result register lets the next request start while it waits
// reset: synchronous, active low; scores read as base, sets and counters cleared
// ----------------------------------------------------------------------------
// locality_score_warp_throttle_top
// Per-warp locality scores with score-ranked exclusive set selection.
// ----------------------------------------------------------------------------
`default_nettype none

module locality_score_warp_throttle_top import lswt_pkg::*; #(
    parameter int NumWarps = WARP_CNT_DEF
) (
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    lswt_chan_if.sink   i_in,
    lswt_chan_if.source o_out,
    lswt_chan_if.sink   i_cfg
);
    t_cmd      cmd;
    t_sts      sts;
    t_out_item res;

    assign i_cfg.ready = 1'b1;
    assign o_out.data  = res;

    lswt_ctrl #(.NumWarps(NumWarps)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    lswt_datapath #(.NumWarps(NumWarps)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_in.data),
        .i_cfg_we (i_cfg.valid),
        .i_cfg    (i_cfg.data),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_res    (res)
    );
endmodule

`default_nettype wire

>>> rtl/core/lswt_checker.sv
// ----------------------------------------------------------------------------
// lswt_checker
// Port-level checks of the warp throttle, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lswt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [30:0] i_cutoff
);
    // a result once shown stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_cutoff_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_cutoff != 31'd0)
        else $error("cutoff reported as zero");

    // one request at a time
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second request taken while busy");
endmodule

bind locality_score_warp_throttle_top lswt_checker u_lswt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_cutoff    (o_out.data.cutoff_now)
);

`default_nettype wire
